FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker in rtl/cau_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Plain invariant, disabled while reset is asserted.
`define CAU_ASSERT_ALW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`endif

FILE: rtl/cau_pkg.sv
// Types and constants for the complex arithmetic unit.
package cau_pkg;
	localparam int FRAC_BITS = 8;
	localparam int CELLS = 16;
	localparam int LAT = CELLS + 4;
	localparam int VAL_W = 33;
	localparam int DEN_W = 32;
	localparam int REM_W = 48;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] a_re;
		logic signed [15:0] a_im;
		logic signed [15:0] b_re;
		logic signed [15:0] b_im;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] res_re;
		logic signed [15:0] res_im;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic                     vld;
		op_t                      op;
		logic                     dz;
		logic                     neg_re;
		logic                     neg_im;
		logic                     big_re;
		logic                     big_im;
		logic signed [VAL_W-1:0]  val_re;
		logic signed [VAL_W-1:0]  val_im;
		logic [REM_W-1:0]         rem_re;
		logic [REM_W-1:0]         rem_im;
		logic [DEN_W-1:0]         den;
		logic [15:0]              q_re;
		logic [15:0]              q_im;
	} cell_t;
endpackage

FILE: rtl/cau_front.sv
// Operand products, sums and divider setup ahead of the cell chain.
module cau_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld,
	input  cau_pkg::cmd_t    cmd,
	output cau_pkg::cell_t   dout
);
	logic vld_s1, vld_s2, vld_s3;
	cau_pkg::op_t op_s1, op_s2;
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic signed [16:0] add_re_s1, add_im_s1;
	logic signed [cau_pkg::VAL_W-1:0] x_re_s2, x_im_s2;
	logic [cau_pkg::DEN_W-1:0] den_s2;
	cau_pkg::cell_t cell_s3, nxt;

	logic signed [cau_pkg::VAL_W-1:0] sh_re, sh_im;
	logic [cau_pkg::DEN_W-1:0] mag_re, mag_im;
	logic [cau_pkg::REM_W-1:0] den16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= cmd.op;
		p_rr_s1 <= cmd.a_re * cmd.b_re;
		p_ii_s1 <= cmd.a_im * cmd.b_im;
		p_ri_s1 <= cmd.a_re * cmd.b_im;
		p_ir_s1 <= cmd.a_im * cmd.b_re;
		p_bb_s1 <= cmd.b_re * cmd.b_re;
		p_cc_s1 <= cmd.b_im * cmd.b_im;
		if (cmd.op == cau_pkg::OP_SUB) begin
			add_re_s1 <= 17'(cmd.a_re) - 17'(cmd.b_re);
			add_im_s1 <= 17'(cmd.a_im) - 17'(cmd.b_im);
		end else begin
			add_re_s1 <= 17'(cmd.a_re) + 17'(cmd.b_re);
			add_im_s1 <= 17'(cmd.a_im) + 17'(cmd.b_im);
		end
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		den_s2 <= 32'(33'(p_bb_s1) + 33'(p_cc_s1));
		case (op_s1)
			cau_pkg::OP_MUL: begin
				x_re_s2 <= 33'(p_rr_s1) - 33'(p_ii_s1);
				x_im_s2 <= 33'(p_ri_s1) + 33'(p_ir_s1);
			end
			cau_pkg::OP_DIV: begin
				x_re_s2 <= 33'(p_rr_s1) + 33'(p_ii_s1);
				x_im_s2 <= 33'(p_ir_s1) - 33'(p_ri_s1);
			end
			default: begin
				x_re_s2 <= 33'(add_re_s1);
				x_im_s2 <= 33'(add_im_s1);
			end
		endcase
	end

	always_comb begin
		sh_re = (x_re_s2 >>> cau_pkg::FRAC_BITS)
			+ ((x_re_s2[32] && (|x_re_s2[cau_pkg::FRAC_BITS-1:0])) ? 33'sd1 : 33'sd0);
		sh_im = (x_im_s2 >>> cau_pkg::FRAC_BITS)
			+ ((x_im_s2[32] && (|x_im_s2[cau_pkg::FRAC_BITS-1:0])) ? 33'sd1 : 33'sd0);
		mag_re = x_re_s2[32] ? 32'(-x_re_s2) : x_re_s2[31:0];
		mag_im = x_im_s2[32] ? 32'(-x_im_s2) : x_im_s2[31:0];
		den16  = 48'(den_s2) << 16;
		nxt        = '0;
		nxt.vld    = vld_s2;
		nxt.op     = op_s2;
		nxt.dz     = (op_s2 == cau_pkg::OP_DIV) && (den_s2 == '0);
		nxt.neg_re = x_re_s2[32];
		nxt.neg_im = x_im_s2[32];
		nxt.rem_re = 48'(mag_re) << cau_pkg::FRAC_BITS;
		nxt.rem_im = 48'(mag_im) << cau_pkg::FRAC_BITS;
		nxt.big_re = nxt.rem_re >= den16;
		nxt.big_im = nxt.rem_im >= den16;
		nxt.den    = den_s2;
		nxt.val_re = (op_s2 == cau_pkg::OP_MUL) ? sh_re : x_re_s2;
		nxt.val_im = (op_s2 == cau_pkg::OP_MUL) ? sh_im : x_im_s2;
	end

	always_ff @(posedge clk) begin
		cell_s3 <= nxt;
	end

	always_comb begin
		dout     = cell_s3;
		dout.vld = vld_s3;
	end
endmodule

FILE: rtl/cau_cell.sv
// One restoring-division cell: one quotient bit per part, then hand on.
module cau_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  cau_pkg::cell_t  d,
	output cau_pkg::cell_t  q
);
	cau_pkg::cell_t nxt, q_q;
	logic vld_q;
	logic [cau_pkg::REM_W-1:0] dsh, r_re, r_im;
	logic ge_re, ge_im;

	always_comb begin
		dsh   = 48'(d.den) << 15;
		ge_re = d.rem_re >= dsh;
		ge_im = d.rem_im >= dsh;
		r_re  = ge_re ? d.rem_re - dsh : d.rem_re;
		r_im  = ge_im ? d.rem_im - dsh : d.rem_im;
		nxt        = d;
		nxt.rem_re = r_re << 1;
		nxt.rem_im = r_im << 1;
		nxt.q_re   = {d.q_re[14:0], ge_re};
		nxt.q_im   = {d.q_im[14:0], ge_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= nxt;
	end

	always_comb begin
		q     = q_q;
		q.vld = vld_q;
	end
endmodule

FILE: rtl/cau_back.sv
// Sign restore, saturation and status for the result beat.
module cau_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cau_pkg::cell_t  d,
	output logic            done,
	output cau_pkg::res_t   res
);
	logic signed [cau_pkg::VAL_W-1:0] m_re, m_im, v_re, v_im;
	logic ovf_re, ovf_im;
	logic signed [15:0] s_re, s_im;
	cau_pkg::res_t res_q;
	logic done_q;

	always_comb begin
		m_re = d.big_re ? 33'sd65536 : 33'(d.q_re);
		m_im = d.big_im ? 33'sd65536 : 33'(d.q_im);
		if (d.op == cau_pkg::OP_DIV) begin
			v_re = d.neg_re ? -m_re : m_re;
			v_im = d.neg_im ? -m_im : m_im;
		end else begin
			v_re = d.val_re;
			v_im = d.val_im;
		end
		ovf_re = (v_re > 33'sd32767) || (v_re < -33'sd32768);
		ovf_im = (v_im > 33'sd32767) || (v_im < -33'sd32768);
		s_re = ovf_re ? (v_re[32] ? 16'sh8000 : 16'sh7fff) : v_re[15:0];
		s_im = ovf_im ? (v_im[32] ? 16'sh8000 : 16'sh7fff) : v_im[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (d.dz) begin
			res_q.res_re <= '0;
			res_q.res_im <= '0;
			res_q.status <= cau_pkg::ST_DZ;
		end else begin
			res_q.res_re <= s_re;
			res_q.res_im <= s_im;
			res_q.status <= (ovf_re || ovf_im) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

FILE: rtl/complex_arith_unit_top.sv
// Every op passes through the same stages from the start beat to the done beat.
// Throughput: one beat per cycle; busy stays low, three front stages, a row of
// 16 restoring-division cells giving one quotient bit each, and one output stage.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
module complex_arith_unit_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cau_pkg::cmd_t  cmd,
	output logic           done,
	output cau_pkg::res_t  res
);
	cau_pkg::cell_t chain [cau_pkg::CELLS+1];

	assign busy = 1'b0;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start && !busy),
		.cmd    (cmd),
		.dout   (chain[0])
	);

	for (genvar i = 0; i < cau_pkg::CELLS; i++) begin : g_cell
		cau_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (chain[cau_pkg::CELLS]),
		.done   (done),
		.res    (res)
	);
endmodule

FILE: rtl/cau_checker.sv
// Port-level checker for the complex arithmetic unit, bound to the top level.
`include "assert_macros.svh"
module cau_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input cau_pkg::res_t  res
);
	logic dz_beat;

	assign dz_beat = done && (res.status == cau_pkg::ST_DZ);

	`CAU_ASSERT_ALW(a_never_busy, clk, arst_n, !busy)
	`CAU_ASSERT_IMP(a_done_has_start, clk, arst_n, done, $past(start, cau_pkg::LAT))
	`CAU_ASSERT_IMP(a_status_code, clk, arst_n, done, res.status <= cau_pkg::ST_DZ)
	`CAU_ASSERT_IMP(a_dz_zero, clk, arst_n, dz_beat, res.res_re == '0 && res.res_im == '0)
endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

FILE: tb/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it.
module tb_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  cau_pkg::cmd_t  cmd,
	input  logic           done,
	input  cau_pkg::res_t  res,
	output int             fails,
	output int             pending
);
	import cau_pkg::*;

	res_t expected_q[$];

	function automatic logic signed [15:0] clamp(input longint v, inout logic ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 16'sd32767;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	function automatic res_t compute(input cmd_t c);
		res_t r;
		longint ar, ai, br, bi, xr, xi, den, scale;
		logic ovf;
		ar = c.a_re;
		ai = c.a_im;
		br = c.b_re;
		bi = c.b_im;
		scale = longint'(1) << FRAC_BITS;
		xr = 0;
		xi = 0;
		ovf = 1'b0;
		r.status = ST_OK;
		case (c.op)
			OP_ADD: begin
				xr = ar + br;
				xi = ai + bi;
			end
			OP_SUB: begin
				xr = ar - br;
				xi = ai - bi;
			end
			OP_MUL: begin
				xr = (ar * br - ai * bi) / scale;
				xi = (ar * bi + ai * br) / scale;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0)
					r.status = ST_DZ;
				else begin
					xr = ((ar * br + ai * bi) * scale) / den;
					xi = ((ai * br - ar * bi) * scale) / den;
				end
			end
		endcase
		if (r.status == ST_OK) begin
			r.res_re = clamp(xr, ovf);
			r.res_im = clamp(xi, ovf);
			if (ovf)
				r.status = ST_OVF;
		end else begin
			r.res_re = '0;
			r.res_im = '0;
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			fails <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(compute(cmd));
			if (done) begin
				if (expected_q.size() == 0) begin
					if (fails < 10)
						$display("unexpected result %h", res);
					fails <= fails + 1;
				end else begin
					e = expected_q.pop_front();
					if (res.res_re !== e.res_re || res.res_im !== e.res_im
						|| res.status !== e.status) begin
						if (fails < 10)
							$display("mismatch exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
								e.res_re, e.res_im, e.status, res.res_re, res.res_im,
								res.status);
						fails <= fails + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/testbench.sv
// Top of the testbench: drives command beats and reports the verdict.
module testbench;
	import cau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy, done;
	res_t res;
	int fails, pending;
	int idle_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	complex_arith_unit_top dut (.clk, .arst_n, .start, .busy, .cmd, .done, .res);
	tb_checker chk (.clk, .arst_n, .start, .busy, .cmd, .done, .res, .fails, .pending);

	function automatic logic [15:0] pick_val();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			4: return 16'(int'($urandom_range(0, 8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(input cmd_t c);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_parts(input op_t o, input logic [15:0] ar, ai, br, bi);
		cmd_t c;
		c.op = o;
		c.a_re = ar;
		c.a_im = ai;
		c.b_re = br;
		c.b_im = bi;
		send(c);
	endtask

	initial begin
		cmd_t c;
		idle_pct = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed beats: extremes, every op, saturation and zero divisor
		send_parts(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_parts(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
		send_parts(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_parts(OP_SUB, 16'h0300, 16'h0100, 16'h0100, 16'h0300);
		send_parts(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_parts(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_parts(OP_MUL, 16'h0100, 16'h0200, 16'h0300, 16'hfc00);
		send_parts(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
		send_parts(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
		send_parts(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_parts(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send_parts(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_parts(OP_DIV, 16'h0100, 16'hff00, 16'h0300, 16'h0000);
		send_parts(OP_DIV, 16'hff01, 16'h0001, 16'h0000, 16'h0003);
		send_parts(OP_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_parts(OP_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h8000);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 85 : (ph == 2) ? 0 : 26;
			repeat (260) begin
				c.op = op_t'($urandom_range(0, 3));
				c.a_re = pick_val();
				c.a_im = pick_val();
				c.b_re = pick_val();
				c.b_im = pick_val();
				if (c.op == OP_DIV && $urandom_range(0, 15) == 0) begin
					c.b_re = '0;
					c.b_im = '0;
				end
				send(c);
			end
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
